// File: rtl/lobm_pkg.sv
// ---------------------------------------------------------------------------
// lobm_pkg
// Shared types and constants of the limit order book matcher.
// ---------------------------------------------------------------------------
package lobm_pkg;

    localparam int TICKER_W   = 10;
    localparam int QTY_W      = 16;
    localparam int PRICE_W    = 20;
    localparam int TICKERS_DEF    = 1024;
    localparam int BOOK_DEPTH_DEF = 16;

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    localparam logic RES_TRADE = 1'b0;
    localparam logic RES_DONE  = 1'b1;

    localparam logic ST_ACCEPTED = 1'b0;
    localparam logic ST_REJECTED = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [TICKER_W-1:0] ticker;
        logic [QTY_W-1:0]    quantity;
        logic [PRICE_W-1:0]  price;
    } order_t;

    typedef struct packed {
        logic                result_kind;
        logic [TICKER_W-1:0] trade_ticker;
        logic [QTY_W-1:0]    traded_qty;
        logic [PRICE_W-1:0]  trade_price;
        logic                status;
        logic                last;
    } result_t;

    typedef struct packed {
        logic [QTY_W-1:0]   qty;
        logic [PRICE_W-1:0] price;
    } entry_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_CNT_LD,
        S_CHECK,
        S_INS_RD,
        S_INS_STEP,
        S_INS_PUT,
        S_HEAD_RD,
        S_HEAD_WAIT,
        S_MATCH,
        S_DROP_RD,
        S_DROP_STEP,
        S_EMIT
    } state_t;

endpackage

// File: rtl/lobm_stream_if.sv
// ---------------------------------------------------------------------------
// lobm_stream_if
// Valid/ready channel carrying one payload per transfer.
// ---------------------------------------------------------------------------
interface lobm_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/limit_order_book_matcher.sv
// ---------------------------------------------------------------------------
// limit_order_book_matcher
// Price-time priority order matching over per-ticker buy and sell books.
// ---------------------------------------------------------------------------
// Usage: orders arrive on the in_ch sink channel, one per transfer. Each
// order yields zero or more trade items and one closing done item (last=1)
// on the out_ch source channel. One order is handled at a time; the next is
// accepted at the earliest in the cycle after the done item has been transferred.
// Books live in one synchronous memory holding both sides; the per-ticker
// counts live in a second one and sit in registers while an order runs.
// After acceptance the ticker is reduced when TICKERS is below 1024 and not a
// power of two of at least 2; then the counts are loaded and the order is
// checked, and a rejected or zero-quantity order ends there. Insertion
// compares resting entries from the tail, moving each worse one up, and then
// writes the new one. Each trade reads both heads, and each head that leaves
// its book has the entries behind it moved up. The closing check ends the
// order, or first reads both heads when it finds the books apart.
// After reset a clearing pass zeroes the count of every ticker while in_ch
// is held off; book entries are only read below the count.
// When the receiver stalls, the pending result holds and the block waits.
// ---------------------------------------------------------------------------
module limit_order_book_matcher
    import lobm_pkg::*;
#(
    parameter int TICKERS    = TICKERS_DEF,
    parameter int BOOK_DEPTH = BOOK_DEPTH_DEF
)(
    input logic         clk,
    input logic         rst_n,
    lobm_stream_if.sink   in_ch,
    lobm_stream_if.source out_ch
);
    localparam int TI_W = (TICKERS > 1) ? $clog2(TICKERS) : 1;
    localparam int DI_W = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
    localparam int CNT_W = $clog2(BOOK_DEPTH + 1);
    localparam int ADDR_W = 1 + TI_W + DI_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int RED_W = TICKER_W + 10;
    // The ticker needs a real reduction only when truncation is not the modulo.
    localparam bit NEEDS_MOD = (TICKERS < (1 << TICKER_W)) && (TICKERS != (1 << TI_W));

    entry_t mem [MEM_DEPTH];
    logic [2*CNT_W-1:0] cnt_mem [TICKERS];   // {sell count, buy count}

    state_t state_reg, state_next;
    order_t ord_reg, ord_next;
    logic [TI_W-1:0] t_reg, t_next;
    logic [TI_W-1:0] clr_reg, clr_next;
    logic [TICKER_W-1:0] red_reg, red_next;
    logic [3:0] mod_k_reg, mod_k_next;
    logic [CNT_W-1:0] pos_reg, pos_next;     // walking index
    logic [CNT_W-1:0] trades_reg, trades_next;
    logic [CNT_W-1:0] bcnt_reg, bcnt_next, scnt_reg, scnt_next;
    logic side_reg, side_next;               // side being shifted on drop
    entry_t bhead_reg, bhead_next, shead_reg, shead_next;
    result_t res_reg, res_next;
    logic res_valid_reg, res_valid_next;
    logic drop_s_reg, drop_s_next;           // sell head still to drop

    logic mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    entry_t mem_wdata, mem_rdata;
    logic cnt_we;
    logic [TI_W-1:0] cnt_waddr, cnt_raddr;
    logic [2*CNT_W-1:0] cnt_wdata, cnt_rdata;

    function automatic logic [ADDR_W-1:0] addr_of(logic s, logic [TI_W-1:0] t,
                                                   logic [CNT_W-1:0] i);
        return {s, t, i[DI_W-1:0]};
    endfunction

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata <= mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rdata <= cnt_mem[cnt_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            res_valid_reg <= 1'b0;
            clr_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            clr_reg       <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ord_reg        <= ord_next;
        t_reg          <= t_next;
        red_reg        <= red_next;
        mod_k_reg      <= mod_k_next;
        pos_reg        <= pos_next;
        trades_reg     <= trades_next;
        bcnt_reg       <= bcnt_next;
        scnt_reg       <= scnt_next;
        side_reg       <= side_next;
        bhead_reg      <= bhead_next;
        shead_reg      <= shead_next;
        res_reg        <= res_next;
        drop_s_reg     <= drop_s_next;
    end

    logic [CNT_W-1:0] own_cnt, drop_cnt;
    logic better_new;
    logic [QTY_W-1:0] tq;
    logic [RED_W-1:0] mod_sub;
    logic mod_ge;
    logic [TICKER_W-1:0] red_after;

    assign own_cnt = (ord_reg.kind == SIDE_SELL) ? scnt_reg : bcnt_reg;
    assign drop_cnt = (side_reg == SIDE_SELL) ? scnt_reg : bcnt_reg;
    assign tq = (bhead_reg.qty < shead_reg.qty) ? bhead_reg.qty : shead_reg.qty;
    // New order goes ahead of an entry only when strictly better.
    assign better_new = (ord_reg.kind == SIDE_BUY) ? (ord_reg.price > mem_rdata.price)
                                                   : (ord_reg.price < mem_rdata.price);

    // One restoring step of ticker modulo TICKERS per cycle, top multiple first.
    assign mod_sub   = RED_W'(TICKERS) << mod_k_reg;
    assign mod_ge    = RED_W'(red_reg) >= mod_sub;
    assign red_after = mod_ge ? (red_reg - TICKER_W'(mod_sub)) : red_reg;

    assign in_ch.ready  = (state_reg == S_IDLE) && !res_valid_reg;
    assign out_ch.valid = res_valid_reg;
    assign out_ch.data  = res_reg;

    always_comb
    begin
        state_next      = state_reg;
        ord_next        = ord_reg;
        t_next          = t_reg;
        clr_next        = clr_reg;
        red_next        = red_reg;
        mod_k_next      = mod_k_reg;
        pos_next        = pos_reg;
        trades_next     = trades_reg;
        bcnt_next       = bcnt_reg;
        scnt_next       = scnt_reg;
        side_next       = side_reg;
        bhead_next      = bhead_reg;
        shead_next      = shead_reg;
        res_next        = res_reg;
        res_valid_next  = res_valid_reg;
        drop_s_next     = drop_s_reg;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_raddr = '0;
        cnt_we    = 1'b0;
        cnt_waddr = '0;
        cnt_wdata = '0;
        cnt_raddr = '0;

        if (res_valid_reg && out_ch.ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == TI_W'(TICKERS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    ord_next    = in_ch.data;
                    red_next    = in_ch.data.ticker;
                    mod_k_next  = 4'(TICKER_W - 1);
                    trades_next = '0;
                    if (NEEDS_MOD)
                    begin
                        state_next = S_MOD;
                    end
                    else
                    begin
                        t_next     = TI_W'(in_ch.data.ticker);
                        cnt_raddr  = TI_W'(in_ch.data.ticker);
                        state_next = S_CNT_LD;
                    end
                end
            end
            S_MOD:
            begin
                red_next   = red_after;
                mod_k_next = mod_k_reg - 1'b1;
                if (mod_k_reg == '0)
                begin
                    t_next     = TI_W'(red_after);
                    cnt_raddr  = TI_W'(red_after);
                    state_next = S_CNT_LD;
                end
            end
            S_CNT_LD:
            begin
                bcnt_next  = cnt_rdata[CNT_W-1:0];
                scnt_next  = cnt_rdata[2*CNT_W-1:CNT_W];
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (own_cnt >= CNT_W'(BOOK_DEPTH) || ord_reg.quantity == '0)
                begin
                    res_next = '{RES_DONE, ord_reg.ticker, '0, '0,
                                 (own_cnt >= CNT_W'(BOOK_DEPTH)) ? ST_REJECTED
                                                                  : ST_ACCEPTED,
                                 1'b1};
                    res_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    pos_next = own_cnt;
                    state_next = (own_cnt == '0) ? S_INS_PUT : S_INS_RD;
                end
            end
            S_INS_RD:
            begin
                mem_raddr  = addr_of(ord_reg.kind, t_reg, pos_reg - 1'b1);
                state_next = S_INS_STEP;
            end
            S_INS_STEP:
            begin
                if (better_new)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = addr_of(ord_reg.kind, t_reg, pos_reg);
                    mem_wdata = mem_rdata;
                    pos_next  = pos_reg - 1'b1;
                    state_next = (pos_reg == CNT_W'(1)) ? S_INS_PUT : S_INS_RD;
                end
                else
                begin
                    state_next = S_INS_PUT;
                end
            end
            S_INS_PUT:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_of(ord_reg.kind, t_reg, pos_reg);
                mem_wdata = '{ord_reg.quantity, ord_reg.price};
                if (ord_reg.kind == SIDE_SELL)
                begin
                    scnt_next = scnt_reg + 1'b1;
                end
                else
                begin
                    bcnt_next = bcnt_reg + 1'b1;
                end
                state_next = S_HEAD_RD;
            end
            S_HEAD_RD:
            begin
                if (bcnt_reg == '0 || scnt_reg == '0 || trades_reg == CNT_W'(BOOK_DEPTH))
                begin
                    if (!res_valid_reg || out_ch.ready)
                    begin
                        res_next = '{RES_DONE, ord_reg.ticker, '0, '0,
                                     ST_ACCEPTED, 1'b1};
                        res_valid_next = 1'b1;
                        cnt_we     = 1'b1;
                        cnt_waddr  = t_reg;
                        cnt_wdata  = {scnt_reg, bcnt_reg};
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    mem_raddr  = addr_of(SIDE_BUY, t_reg, '0);
                    state_next = S_HEAD_WAIT;
                end
            end
            S_HEAD_WAIT:
            begin
                bhead_next = mem_rdata;
                mem_raddr  = addr_of(SIDE_SELL, t_reg, '0);
                state_next = S_MATCH;
            end
            S_MATCH:
            begin
                shead_next = mem_rdata;
                if (bhead_reg.price < mem_rdata.price)
                begin
                    trades_next = CNT_W'(BOOK_DEPTH);
                    state_next = S_HEAD_RD;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // Output one trade, write back a head left partly filled and start dropping each filled head.
                if (!res_valid_reg || out_ch.ready)
                begin
                    res_next = '{RES_TRADE, ord_reg.ticker, tq, shead_reg.price,
                                 ST_ACCEPTED, 1'b0};
                    res_valid_next = 1'b1;
                    trades_next = trades_reg + 1'b1;
                    drop_s_next = 1'b0;
                    if (bhead_reg.qty == tq)
                    begin
                        side_next = SIDE_BUY;
                        pos_next  = CNT_W'(1);
                        drop_s_next = (shead_reg.qty == tq);
                        state_next = S_DROP_RD;
                        if (shead_reg.qty != tq)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = addr_of(SIDE_SELL, t_reg, '0);
                            mem_wdata = '{shead_reg.qty - tq, shead_reg.price};
                        end
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = addr_of(SIDE_BUY, t_reg, '0);
                        mem_wdata = '{bhead_reg.qty - tq, bhead_reg.price};
                        side_next = SIDE_SELL;
                        pos_next  = CNT_W'(1);
                        state_next = S_DROP_RD;
                    end
                end
            end
            S_DROP_RD:
            begin
                if (pos_reg >= drop_cnt)
                begin
                    if (side_reg == SIDE_SELL)
                    begin
                        scnt_next = scnt_reg - 1'b1;
                    end
                    else
                    begin
                        bcnt_next = bcnt_reg - 1'b1;
                    end
                    if (side_reg == SIDE_BUY && drop_s_reg)
                    begin
                        side_next   = SIDE_SELL;
                        pos_next    = CNT_W'(1);
                        drop_s_next = 1'b0;
                    end
                    else
                    begin
                        state_next = S_HEAD_RD;
                    end
                end
                else
                begin
                    mem_raddr  = addr_of(side_reg, t_reg, pos_reg);
                    state_next = S_DROP_STEP;
                end
            end
            S_DROP_STEP:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_of(side_reg, t_reg, pos_reg - 1'b1);
                mem_wdata = mem_rdata;
                pos_next  = pos_reg + 1'b1;
                state_next = S_DROP_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/lobm_checker.sv
// ---------------------------------------------------------------------------
// lobm_checker
// Port-level checks of the matcher's handshakes and result framing.
// ---------------------------------------------------------------------------
module lobm_checker
    import lobm_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_ready,
    input logic    out_valid,
    input logic    out_ready,
    input result_t out_data
);
    // A stalled result must hold.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed under stall");

    // Last marks exactly the done items.
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.last == (out_data.result_kind == RES_DONE)))
        else $error("last flag does not match done item");

    // Trades carry nonzero quantity and ok status.
    a_trade: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.result_kind == RES_TRADE |->
            out_data.traded_qty != '0 && out_data.status == ST_ACCEPTED)
        else $error("malformed trade item");

    // No new order is taken while a result is pending.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("order accepted while result pending");

    // A rejected done item carries zero quantity and price.
    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_REJECTED |->
            out_data.traded_qty == '0 && out_data.trade_price == '0)
        else $error("reject item has payload");
endmodule

bind limit_order_book_matcher lobm_checker u_lobm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);
